FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the crossover RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk outside of reset.
`define TWCF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every rising edge of clk, reset included.
`define TWCF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

FILE: rtl/twcf_pkg.sv
// ----------------------------------------------------------------------------
// twcf_pkg
// Widths, types, register indexes and limits of the two-way crossover.
// ----------------------------------------------------------------------------
`default_nettype none

package twcf_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 22;
    localparam int COEF_BITS      = COEF_FRAC_BITS + 2;
    localparam int GAIN_BITS      = COEF_BITS - 1;
    localparam int NUM_BITS       = SAMPLE_BITS + 2;
    localparam int FF_PROD_BITS   = NUM_BITS + GAIN_BITS + 1;
    localparam int FB_PROD_BITS   = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_BITS       = FF_PROD_BITS + 2;
    localparam int SHIFT_BITS     = ACC_BITS - COEF_FRAC_BITS;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = COEF_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [NUM_BITS-1:0]    num_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic        [GAIN_BITS-1:0]   gain_t;

    typedef struct packed {
        coef_t a1;
        coef_t a2;
    } fb_coef_t;

    localparam logic [CFG_INDEX_BITS-1:0] REG_BYPASS    = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_GAIN  = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_GAIN = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_FB_A1     = CFG_INDEX_BITS'(3);
    localparam logic [CFG_INDEX_BITS-1:0] REG_FB_A2     = CFG_INDEX_BITS'(4);

    localparam sample_t SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
        {{(ACC_BITS-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};

endpackage

`default_nettype wire

FILE: rtl/twcf_band.sv
// ----------------------------------------------------------------------------
// twcf_band
// One second-order band: feed-forward product, two feedback products,
// single rounding and saturation to the sample width.
// ----------------------------------------------------------------------------
`default_nettype none

module twcf_band (
    input  wire twcf_pkg::num_t    num,
    input  wire twcf_pkg::gain_t   gain,
    input  wire twcf_pkg::sample_t y1,
    input  wire twcf_pkg::sample_t y2,
    input  wire twcf_pkg::fb_coef_t coef,
    output twcf_pkg::sample_t      result
);

    logic signed [twcf_pkg::FF_PROD_BITS-1:0] ff_prod;
    logic signed [twcf_pkg::FB_PROD_BITS-1:0] fb1_prod;
    logic signed [twcf_pkg::FB_PROD_BITS-1:0] fb2_prod;
    logic signed [twcf_pkg::ACC_BITS-1:0]     acc;
    logic signed [twcf_pkg::ACC_BITS-1:0]     rnd;
    logic signed [twcf_pkg::SHIFT_BITS-1:0]   shifted;

    assign ff_prod  = num * $signed({1'b0, gain});
    assign fb1_prod = coef.a1 * y1;
    assign fb2_prod = coef.a2 * y2;

    assign acc = twcf_pkg::ACC_BITS'(ff_prod)
               - twcf_pkg::ACC_BITS'(fb1_prod)
               - twcf_pkg::ACC_BITS'(fb2_prod);
    assign rnd     = acc + twcf_pkg::ROUND_HALF;
    assign shifted = $signed(rnd[twcf_pkg::ACC_BITS-1:twcf_pkg::COEF_FRAC_BITS]);

    always_comb
    begin
        if (shifted > twcf_pkg::SHIFT_BITS'(twcf_pkg::SAT_MAX))
        begin
            result = twcf_pkg::SAT_MAX;
        end
        else if (shifted < twcf_pkg::SHIFT_BITS'(twcf_pkg::SAT_MIN))
        begin
            result = twcf_pkg::SAT_MIN;
        end
        else
        begin
            result = shifted[twcf_pkg::SAMPLE_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/two_way_crossover_filter.sv
// ----------------------------------------------------------------------------
// two_way_crossover_filter
// Second-order low/high crossover with a shared feedback denominator,
// polarity-inverted high band and a bypass mode.
// ----------------------------------------------------------------------------
// Channel  | Handshake             | Payload
// input    | in_valid / in_ready   | sample_in
// output   | out_valid / out_ready | low_out, high_out
// config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One word per cycle while the output does not stall. The feedback path
// through the history registers sets that rate: each word is filtered
// between the input register and the result register.
// Reset clears histories, valid flags and configuration (bypass on).
// A stalled output holds its result while one more word waits in the input
// register; config writes are taken every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module two_way_crossover_filter (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    in_valid,
    output logic                                   in_ready,
    input  wire twcf_pkg::sample_t                 sample_in,
    output logic                                   out_valid,
    input  wire                                    out_ready,
    output twcf_pkg::sample_t                      low_out,
    output twcf_pkg::sample_t                      high_out,
    input  wire                                    cfg_valid,
    output logic                                   cfg_ready,
    input  wire [twcf_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire [twcf_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

`include "assert_macros.svh"

    logic               bypass_reg;
    twcf_pkg::gain_t    low_gain_reg;
    twcf_pkg::gain_t    high_gain_reg;
    twcf_pkg::fb_coef_t coef_reg;

    logic               s1_valid_reg;
    twcf_pkg::sample_t  x_reg;
    logic               out_valid_reg;
    twcf_pkg::sample_t  low_out_reg;
    twcf_pkg::sample_t  high_out_reg;

    twcf_pkg::sample_t  x_hist1_reg;
    twcf_pkg::sample_t  x_hist2_reg;
    twcf_pkg::sample_t  low_hist1_reg;
    twcf_pkg::sample_t  low_hist2_reg;
    twcf_pkg::sample_t  high_hist1_reg;
    twcf_pkg::sample_t  high_hist2_reg;

    logic               advance;
    twcf_pkg::num_t     num_low;
    twcf_pkg::num_t     num_high;
    twcf_pkg::sample_t  low_band;
    twcf_pkg::sample_t  high_band;
    twcf_pkg::sample_t  low_next;
    twcf_pkg::sample_t  high_next;
    twcf_pkg::sample_t  high_out_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg    <= 1'b1;
            low_gain_reg  <= '0;
            high_gain_reg <= '0;
            coef_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                twcf_pkg::REG_BYPASS:    bypass_reg    <= cfg_data[0];
                twcf_pkg::REG_LOW_GAIN:  low_gain_reg  <= cfg_data[twcf_pkg::GAIN_BITS-1:0];
                twcf_pkg::REG_HIGH_GAIN: high_gain_reg <= cfg_data[twcf_pkg::GAIN_BITS-1:0];
                twcf_pkg::REG_FB_A1:     coef_reg.a1   <= cfg_data[twcf_pkg::COEF_BITS-1:0];
                twcf_pkg::REG_FB_A2:     coef_reg.a2   <= cfg_data[twcf_pkg::COEF_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign low_out   = low_out_reg;
    assign high_out  = high_out_reg;

    assign num_low  = twcf_pkg::NUM_BITS'(x_reg) + (twcf_pkg::NUM_BITS'(x_hist1_reg) <<< 1)
                    + twcf_pkg::NUM_BITS'(x_hist2_reg);
    assign num_high = twcf_pkg::NUM_BITS'(x_reg) - (twcf_pkg::NUM_BITS'(x_hist1_reg) <<< 1)
                    + twcf_pkg::NUM_BITS'(x_hist2_reg);

    twcf_band u_low_band (
        .num    (num_low),
        .gain   (low_gain_reg),
        .y1     (low_hist1_reg),
        .y2     (low_hist2_reg),
        .coef   (coef_reg),
        .result (low_band)
    );

    twcf_band u_high_band (
        .num    (num_high),
        .gain   (high_gain_reg),
        .y1     (high_hist1_reg),
        .y2     (high_hist2_reg),
        .coef   (coef_reg),
        .result (high_band)
    );

    always_comb
    begin
        if (bypass_reg)
        begin
            low_next  = x_reg;
            high_next = x_reg;
        end
        else
        begin
            low_next  = low_band;
            high_next = high_band;
        end
        if (high_next == twcf_pkg::SAT_MIN)
        begin
            high_out_next = twcf_pkg::SAT_MAX;
        end
        else
        begin
            high_out_next = -high_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x_reg <= sample_in;
        end
        if (advance)
        begin
            low_out_reg  <= low_next;
            high_out_reg <= high_out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_hist1_reg    <= '0;
            x_hist2_reg    <= '0;
            low_hist1_reg  <= '0;
            low_hist2_reg  <= '0;
            high_hist1_reg <= '0;
            high_hist2_reg <= '0;
        end
        else if (advance)
        begin
            x_hist1_reg    <= x_reg;
            x_hist2_reg    <= x_hist1_reg;
            low_hist1_reg  <= low_next;
            low_hist2_reg  <= low_hist1_reg;
            high_hist1_reg <= high_next;
            high_hist2_reg <= high_hist1_reg;
        end
    end

    // A word in the input register is never dropped while the output stalls.
    `TWCF_ASSERT(a_s1_held, s1_valid_reg && !advance |=> s1_valid_reg, "input word lost")

    `TWCF_ASSERT(a_result_loaded, advance |=> out_valid_reg, "result not presented")

    `TWCF_ASSERT(a_x_hist_shift, advance |=> x_hist1_reg == $past(x_reg),
                 "input history not advanced")

    `TWCF_ASSERT(a_bypass_hist,
                 bypass_reg && advance |=>
                 (low_hist1_reg == $past(x_reg)) && (high_hist1_reg == $past(x_reg)),
                 "bypass history mismatch")

    // The inverted high band saturates, so it can never be the most negative code.
    `TWCF_ASSERT_ALWAYS(a_high_no_min, out_valid_reg |-> high_out_reg != twcf_pkg::SAT_MIN, "high output not saturated")

endmodule

`default_nettype wire
